// File: rtl/core/vtfp_pkg.sv
package vtfp_pkg;

	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS = 16;
	localparam int ID_BITS = 32;
	localparam int ACCUM_BITS = 64;

	localparam logic [CFG_DATA_BITS-1:0] MAGIC_RESET = 16'hABCF;
	localparam logic [CFG_DATA_BITS-1:0] MAX_PLEN_RESET = 16'hFFFF;
	localparam logic [7:0] COMMA_CHAR = 8'h2C;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_MAGIC_WORD = 2'd0,
		REG_MAX_PAYLOAD_LEN = 2'd1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		PH_MAGIC_HI = 3'd0,
		PH_MAGIC_LO = 3'd1,
		PH_FRAME_LEN = 3'd2,
		PH_TOKEN_ID = 3'd3,
		PH_TOKEN_LEN = 3'd4,
		PH_PAYLOAD = 3'd5,
		PH_COMMA = 3'd6
	} phase_t;

	typedef enum logic [3:0] {
		EV_NONE = 4'd0,
		EV_HEADER = 4'd1,
		EV_BYTE = 4'd2,
		EV_OK = 4'd3,
		EV_BAD_MAGIC = 4'd4,
		EV_NO_COMMA = 4'd5,
		EV_OVERRUN = 4'd6,
		EV_TOO_LONG = 4'd7,
		EV_VARINT_LONG = 4'd8
	} evt_t;

	typedef struct packed {
		logic [7:0] data;
		logic more;
		logic comma;
	} byte_item_t;

endpackage

// File: rtl/core/vtfp_if.sv
interface vtfp_in_if;
	logic valid;
	logic ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface vtfp_out_if #(
	parameter int OFFSET_BITS = 24,
	parameter int PAYLOAD_LEN_BITS = 16
);
	logic valid;
	logic ready;
	logic [3:0] event_res;
	logic [31:0] token_id;
	logic [PAYLOAD_LEN_BITS-1:0] payload_len;
	logic [OFFSET_BITS-1:0] store_offset;
	logic [7:0] out_byte;

	modport source (output valid, output event_res, output token_id, output payload_len,
		output store_offset, output out_byte, input ready);
	modport sink (input valid, input event_res, input token_id, input payload_len,
		input store_offset, input out_byte, output ready);
endinterface

interface vtfp_cfg_if;
	logic valid;
	logic ready;
	logic [1:0] reg_index;
	logic [15:0] wr_data;

	modport source (output valid, output reg_index, output wr_data, input ready);
	modport sink (input valid, input reg_index, input wr_data, output ready);
endinterface

// File: rtl/core/vtfp_front.sv
module vtfp_front (
	input logic clk,
	input logic arst_n,
	vtfp_in_if.sink in_ch,
	output logic item_valid,
	output vtfp_pkg::byte_item_t item,
	input logic item_ready
);
	import vtfp_pkg::*;

	localparam int DEPTH = 2;
	localparam int PTR_BITS = $clog2(DEPTH);

	byte_item_t mem_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [PTR_BITS:0] count_q;
	byte_item_t new_item;
	logic push;
	logic pop;

	assign in_ch.ready = (count_q != (PTR_BITS+1)'(DEPTH));
	assign push = in_ch.valid && in_ch.ready;
	assign item_valid = (count_q != '0);
	assign pop = item_valid && item_ready;
	assign item = mem_q[rd_ptr_q];

	always_comb begin
		new_item.data = in_ch.in_byte;
		new_item.more = in_ch.in_byte[7];
		new_item.comma = (in_ch.in_byte == COMMA_CHAR);
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_BITS'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (PTR_BITS+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PTR_BITS+1)'(1);
			end
		end
	end

endmodule

// File: rtl/core/vtfp_back.sv
module vtfp_back #(
	parameter int OFFSET_BITS = 24,
	parameter int PAYLOAD_LEN_BITS = 16,
	parameter int MAX_VARINT_BYTES = 10
) (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input vtfp_pkg::byte_item_t item,
	output logic item_ready,
	vtfp_cfg_if.sink cfg_ch,
	vtfp_out_if.source out_ch
);
	import vtfp_pkg::*;

	localparam logic [ACCUM_BITS-1:0] PLEN_MASK =
		(ACCUM_BITS'(1) << PAYLOAD_LEN_BITS) - ACCUM_BITS'(1);

	logic [CFG_DATA_BITS-1:0] magic_q;
	logic [CFG_DATA_BITS-1:0] max_plen_q;

	phase_t phase_q, phase_d;
	logic [ACCUM_BITS-1:0] accum_q, accum_d;
	logic [3:0] cnt_q, cnt_d;
	logic [ACCUM_BITS-1:0] frame_left_q, frame_left_d;
	logic [PAYLOAD_LEN_BITS-1:0] payload_left_q, payload_left_d;
	logic [OFFSET_BITS-1:0] wr_off_q, wr_off_d;
	logic [ID_BITS-1:0] cur_id_q, cur_id_d;

	logic out_valid_q;
	evt_t ev_q;
	logic [ID_BITS-1:0] id_q;
	logic [PAYLOAD_LEN_BITS-1:0] plen_q;
	logic [OFFSET_BITS-1:0] off_q;
	logic [7:0] ob_q;

	evt_t ev_d;
	logic [ID_BITS-1:0] id_d;
	logic [PAYLOAD_LEN_BITS-1:0] plen_d;
	logic [OFFSET_BITS-1:0] off_d;
	logic [7:0] ob_d;

	logic pop;
	logic [6:0] shift_amt;
	logic [ACCUM_BITS-1:0] acc_fed;
	logic [3:0] cnt_fed;
	logic vi_long;
	logic [PAYLOAD_LEN_BITS-1:0] pl_dec;

	assign item_ready = !out_valid_q || out_ch.ready;
	assign pop = item_valid && item_ready;
	assign cfg_ch.ready = 1'b1;

	assign out_ch.valid = out_valid_q;
	assign out_ch.event_res = ev_q;
	assign out_ch.token_id = id_q;
	assign out_ch.payload_len = plen_q;
	assign out_ch.store_offset = off_q;
	assign out_ch.out_byte = ob_q;

	assign shift_amt = 7'(cnt_q) * 7'd7;
	assign acc_fed = accum_q | (ACCUM_BITS'(item.data[6:0]) << shift_amt);
	assign cnt_fed = cnt_q + 4'd1;
	assign vi_long = item.more && (cnt_fed >= 4'(MAX_VARINT_BYTES));
	assign pl_dec = payload_left_q - PAYLOAD_LEN_BITS'(1);

	always_comb begin
		phase_d = phase_q;
		accum_d = accum_q;
		cnt_d = cnt_q;
		frame_left_d = frame_left_q;
		payload_left_d = payload_left_q;
		wr_off_d = wr_off_q;
		cur_id_d = cur_id_q;
		ev_d = EV_NONE;
		id_d = '0;
		plen_d = '0;
		off_d = '0;
		ob_d = '0;
		case (phase_q)
			PH_MAGIC_HI: begin
				accum_d = ACCUM_BITS'(item.data);
				phase_d = PH_MAGIC_LO;
			end
			PH_MAGIC_LO: begin
				if ({accum_q[7:0], item.data} != magic_q) begin
					ev_d = EV_BAD_MAGIC;
					phase_d = PH_MAGIC_HI;
				end else begin
					wr_off_d = OFFSET_BITS'(1);
					frame_left_d = '0;
					payload_left_d = '0;
					phase_d = PH_FRAME_LEN;
				end
				accum_d = '0;
				cnt_d = '0;
			end
			PH_FRAME_LEN: begin
				accum_d = acc_fed;
				cnt_d = cnt_fed;
				if (vi_long) begin
					ev_d = EV_VARINT_LONG;
					phase_d = PH_MAGIC_HI;
				end else if (!item.more) begin
					frame_left_d = acc_fed;
					phase_d = (acc_fed == '0) ? PH_COMMA : PH_TOKEN_ID;
					accum_d = '0;
					cnt_d = '0;
				end
			end
			PH_TOKEN_ID, PH_TOKEN_LEN, PH_PAYLOAD: begin
				if (frame_left_q == '0) begin
					ev_d = EV_OVERRUN;
					phase_d = PH_MAGIC_HI;
				end else begin
					frame_left_d = frame_left_q - ACCUM_BITS'(1);
					if (phase_q == PH_PAYLOAD) begin
						ev_d = EV_BYTE;
						off_d = wr_off_q;
						ob_d = item.data;
						if (wr_off_q != '1) begin
							wr_off_d = wr_off_q + OFFSET_BITS'(1);
						end
						payload_left_d = pl_dec;
						if (pl_dec == '0) begin
							phase_d = (frame_left_d == '0) ? PH_COMMA : PH_TOKEN_ID;
							accum_d = '0;
							cnt_d = '0;
						end
					end else begin
						accum_d = acc_fed;
						cnt_d = cnt_fed;
						if (vi_long) begin
							ev_d = EV_VARINT_LONG;
							phase_d = PH_MAGIC_HI;
						end else if (!item.more && phase_q == PH_TOKEN_ID) begin
							cur_id_d = acc_fed[ID_BITS-1:0];
							phase_d = PH_TOKEN_LEN;
							accum_d = '0;
							cnt_d = '0;
						end else if (!item.more) begin
							if (acc_fed > ACCUM_BITS'(max_plen_q) || acc_fed > PLEN_MASK) begin
								ev_d = EV_TOO_LONG;
								phase_d = PH_MAGIC_HI;
							end else begin
								ev_d = EV_HEADER;
								id_d = cur_id_q;
								plen_d = acc_fed[PAYLOAD_LEN_BITS-1:0];
								off_d = wr_off_q;
								payload_left_d = acc_fed[PAYLOAD_LEN_BITS-1:0];
								accum_d = '0;
								cnt_d = '0;
								if (acc_fed != '0) begin
									phase_d = PH_PAYLOAD;
								end else begin
									phase_d = (frame_left_d == '0) ? PH_COMMA : PH_TOKEN_ID;
								end
							end
						end
					end
				end
			end
			default: begin
				ev_d = item.comma ? EV_OK : EV_NO_COMMA;
				phase_d = PH_MAGIC_HI;
				accum_d = '0;
				cnt_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q <= MAGIC_RESET;
			max_plen_q <= MAX_PLEN_RESET;
		end else if (cfg_ch.valid && cfg_ch.ready) begin
			case (cfg_ch.reg_index)
				REG_MAGIC_WORD: magic_q <= cfg_ch.wr_data;
				REG_MAX_PAYLOAD_LEN: max_plen_q <= cfg_ch.wr_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MAGIC_HI;
			accum_q <= '0;
			cnt_q <= '0;
			frame_left_q <= '0;
			payload_left_q <= '0;
			wr_off_q <= OFFSET_BITS'(1);
			cur_id_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q <= phase_d;
				accum_q <= accum_d;
				cnt_q <= cnt_d;
				frame_left_q <= frame_left_d;
				payload_left_q <= payload_left_d;
				wr_off_q <= wr_off_d;
				cur_id_q <= cur_id_d;
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ev_q <= ev_d;
			id_q <= id_d;
			plen_q <= plen_d;
			off_q <= off_d;
			ob_q <= ob_d;
		end
	end

endmodule

// File: rtl/core/varint_tagged_frame_parser_top.sv
// Parses a byte stream of tagged frames (magic word, varint frame length, id/length/payload
// tokens, closing comma) and returns exactly one result for every byte transferred in. The
// parser sustains one byte per clock cycle while the output is ready; each byte is
// written into the two-entry input queue and its result then into the output register.
// The per-byte state update in the back end is the single loop that sets this rate. When
// the output is stalled, up to two more bytes are still taken into the queue.
// Configuration registers are written through their own channel, which is always ready.
module varint_tagged_frame_parser_top #(
	parameter int OFFSET_BITS = 24,
	parameter int PAYLOAD_LEN_BITS = 16,
	parameter int MAX_VARINT_BYTES = 10
) (
	input logic clk,
	input logic arst_n,
	vtfp_in_if.sink in_ch,
	vtfp_cfg_if.sink cfg_ch,
	vtfp_out_if.source out_ch
);
	import vtfp_pkg::*;

	logic item_valid;
	logic item_ready;
	byte_item_t item;

	vtfp_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.item_valid(item_valid),
		.item(item),
		.item_ready(item_ready)
	);

	vtfp_back #(
		.OFFSET_BITS(OFFSET_BITS),
		.PAYLOAD_LEN_BITS(PAYLOAD_LEN_BITS),
		.MAX_VARINT_BYTES(MAX_VARINT_BYTES)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item(item),
		.item_ready(item_ready),
		.cfg_ch(cfg_ch),
		.out_ch(out_ch)
	);

endmodule

// File: tb/sv/vtfp_frame_checker.sv
`timescale 1ns / 1ps

module vtfp_frame_checker #(
	parameter int OFFSET_BITS = 24,
	parameter int PAYLOAD_LEN_BITS = 16,
	parameter int MAX_VARINT_BYTES = 10
) (
	input logic clk,
	input logic arst_n,
	vtfp_in_if in_mon,
	vtfp_cfg_if cfg_mon,
	vtfp_out_if out_mon,
	output int errors,
	output int pending
);
	import vtfp_pkg::*;

	typedef enum int {
		VI_MORE,
		VI_DONE,
		VI_OVERLONG
	} varint_status_t;

	typedef struct packed {
		evt_t ev;
		logic [ID_BITS-1:0] id;
		logic [PAYLOAD_LEN_BITS-1:0] plen;
		logic [OFFSET_BITS-1:0] off;
		logic [7:0] data;
	} parse_result_t;

	parse_result_t expected_results[$];

	phase_t ph;
	logic [ACCUM_BITS-1:0] acc;
	int vcnt;
	logic [ACCUM_BITS-1:0] frame_left;
	logic [PAYLOAD_LEN_BITS-1:0] pay_left;
	logic [OFFSET_BITS-1:0] wr_off;
	logic [ID_BITS-1:0] cur_id;
	logic [CFG_DATA_BITS-1:0] magic;
	logic [CFG_DATA_BITS-1:0] max_plen;

	task automatic report_mismatch(input string field, input logic [63:0] got,
		input logic [63:0] want);
		$display("%t mismatch on %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
		errors++;
	endtask

	function automatic void restart_varint();
		acc = '0;
		vcnt = 0;
	endfunction

	function automatic varint_status_t feed_varint(input logic [7:0] b);
		if (7 * vcnt < ACCUM_BITS) begin
			acc = acc | (ACCUM_BITS'(b[6:0]) << (7 * vcnt));
		end
		vcnt++;
		if (!b[7]) return VI_DONE;
		if (vcnt >= MAX_VARINT_BYTES) return VI_OVERLONG;
		return VI_MORE;
	endfunction

	function automatic void close_token();
		ph = (frame_left == '0) ? PH_COMMA : PH_TOKEN_ID;
		restart_varint();
	endfunction

	function automatic parse_result_t parse_byte(input logic [7:0] b);
		parse_result_t r;
		varint_status_t st;
		r = '0;
		r.ev = EV_NONE;
		case (ph)
			PH_MAGIC_HI: begin
				acc = ACCUM_BITS'(b);
				ph = PH_MAGIC_LO;
			end
			PH_MAGIC_LO: begin
				if ({acc[7:0], b} != magic) begin
					r.ev = EV_BAD_MAGIC;
					ph = PH_MAGIC_HI;
				end else begin
					wr_off = OFFSET_BITS'(1);
					frame_left = '0;
					pay_left = '0;
					ph = PH_FRAME_LEN;
				end
				restart_varint();
			end
			PH_FRAME_LEN: begin
				st = feed_varint(b);
				if (st == VI_OVERLONG) begin
					r.ev = EV_VARINT_LONG;
					ph = PH_MAGIC_HI;
				end else if (st == VI_DONE) begin
					frame_left = acc;
					close_token();
				end
			end
			PH_TOKEN_ID, PH_TOKEN_LEN, PH_PAYLOAD: begin
				if (frame_left == '0) begin
					r.ev = EV_OVERRUN;
					ph = PH_MAGIC_HI;
				end else begin
					frame_left = frame_left - ACCUM_BITS'(1);
					if (ph == PH_PAYLOAD) begin
						r.ev = EV_BYTE;
						r.off = wr_off;
						r.data = b;
						if (wr_off != '1) wr_off = wr_off + OFFSET_BITS'(1);
						pay_left = pay_left - PAYLOAD_LEN_BITS'(1);
						if (pay_left == '0) close_token();
					end else begin
						st = feed_varint(b);
						if (st == VI_OVERLONG) begin
							r.ev = EV_VARINT_LONG;
							ph = PH_MAGIC_HI;
						end else if (st == VI_DONE && ph == PH_TOKEN_ID) begin
							cur_id = acc[ID_BITS-1:0];
							ph = PH_TOKEN_LEN;
							restart_varint();
						end else if (st == VI_DONE) begin
							if (acc > ACCUM_BITS'(max_plen) || (acc >> PAYLOAD_LEN_BITS) != '0) begin
								r.ev = EV_TOO_LONG;
								ph = PH_MAGIC_HI;
							end else begin
								r.ev = EV_HEADER;
								r.id = cur_id;
								r.plen = acc[PAYLOAD_LEN_BITS-1:0];
								r.off = wr_off;
								pay_left = acc[PAYLOAD_LEN_BITS-1:0];
								if (pay_left != '0) begin
									ph = PH_PAYLOAD;
									restart_varint();
								end else begin
									close_token();
								end
							end
						end
					end
				end
			end
			default: begin
				r.ev = (b == COMMA_CHAR) ? EV_OK : EV_NO_COMMA;
				ph = PH_MAGIC_HI;
				restart_varint();
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		parse_result_t want;
		if (!arst_n) begin
			ph = PH_MAGIC_HI;
			restart_varint();
			frame_left = '0;
			pay_left = '0;
			wr_off = OFFSET_BITS'(1);
			cur_id = '0;
			magic = MAGIC_RESET;
			max_plen = MAX_PLEN_RESET;
			expected_results.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (cfg_mon.valid && cfg_mon.ready) begin
				case (cfg_reg_t'(cfg_mon.reg_index))
					REG_MAGIC_WORD: magic = cfg_mon.wr_data;
					REG_MAX_PAYLOAD_LEN: max_plen = cfg_mon.wr_data;
					default: ;
				endcase
			end
			if (in_mon.valid && in_mon.ready) begin
				expected_results.push_back(parse_byte(in_mon.in_byte));
			end
			if (out_mon.valid && out_mon.ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with nothing expected", 64'(out_mon.event_res), 64'd0);
				end else begin
					want = expected_results.pop_front();
					if (out_mon.event_res !== want.ev)
						report_mismatch("event_res", 64'(out_mon.event_res), 64'(want.ev));
					if (out_mon.token_id !== want.id)
						report_mismatch("token_id", 64'(out_mon.token_id), 64'(want.id));
					if (out_mon.payload_len !== want.plen)
						report_mismatch("payload_len", 64'(out_mon.payload_len), 64'(want.plen));
					if (out_mon.store_offset !== want.off)
						report_mismatch("store_offset", 64'(out_mon.store_offset), 64'(want.off));
					if (out_mon.out_byte !== want.data)
						report_mismatch("out_byte", 64'(out_mon.out_byte), 64'(want.data));
				end
			end
			pending = expected_results.size();
		end
	end

endmodule

// File: tb/sv/varint_tagged_frame_parser_top_tb.sv
`timescale 1ns / 1ps

module varint_tagged_frame_parser_top_tb;
	import vtfp_pkg::*;

	localparam int OFFSET_BITS = 24;
	localparam int PAYLOAD_LEN_BITS = 16;
	localparam int MAX_VARINT_BYTES = 10;
	localparam int CLK_PERIOD = 8;
	localparam int HOLD_CYCLES = 80;
	localparam int BYTES_PER_PHASE = 85;
	localparam int LIMIT_NS = 4000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	vtfp_in_if in_ch ();
	vtfp_cfg_if cfg_ch ();
	vtfp_out_if #(.OFFSET_BITS(OFFSET_BITS), .PAYLOAD_LEN_BITS(PAYLOAD_LEN_BITS)) out_ch ();

	int chk_errors;
	int chk_pending;

	logic [7:0] stream[$];
	logic [7:0] tok[$];
	logic [CFG_DATA_BITS-1:0] cur_magic;
	logic [CFG_DATA_BITS-1:0] cur_max;
	bit burst = 1'b0;
	bit hold_off = 1'b0;
	int sent;

	varint_tagged_frame_parser_top #(
		.OFFSET_BITS(OFFSET_BITS),
		.PAYLOAD_LEN_BITS(PAYLOAD_LEN_BITS),
		.MAX_VARINT_BYTES(MAX_VARINT_BYTES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.cfg_ch(cfg_ch),
		.out_ch(out_ch)
	);

	vtfp_frame_checker #(
		.OFFSET_BITS(OFFSET_BITS),
		.PAYLOAD_LEN_BITS(PAYLOAD_LEN_BITS),
		.MAX_VARINT_BYTES(MAX_VARINT_BYTES)
	) frame_chk (
		.clk(clk),
		.arst_n(arst_n),
		.in_mon(in_ch),
		.cfg_mon(cfg_ch),
		.out_mon(out_ch),
		.errors(chk_errors),
		.pending(chk_pending)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic int pick_gap();
		int r;
		if (burst) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [63:0] pick_plen();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6) return 64'($urandom_range(0, 5));
		if (r < 8) return (cur_max <= 16'd48) ? 64'(cur_max) : 64'($urandom_range(6, 48));
		if (r == 8) return 64'(cur_max) + 64'd1;
		return {$urandom, $urandom} | 64'h1_0000;
	endfunction

	task automatic put_varint(input logic [63:0] v, input int extra, input bit into_token);
		int n;
		logic [63:0] t;
		logic [7:0] b;
		n = 1;
		t = v >> 7;
		while (t != '0) begin
			n++;
			t = t >> 7;
		end
		n = n + extra;
		if (n > MAX_VARINT_BYTES) n = MAX_VARINT_BYTES;
		for (int i = 0; i < n; i++) begin
			b = {1'b0, 7'(v >> (7 * i))};
			b[7] = (i < n - 1);
			if (into_token) tok.push_back(b);
			else stream.push_back(b);
		end
	endtask

	task automatic add_token();
		int r;
		logic [63:0] plen;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			repeat (9) tok.push_back(8'hFF);
			tok.push_back(8'($urandom_range(0, 127)));
		end else begin
			put_varint((r < 5) ? 64'($urandom_range(0, 127)) :
				(r < 8) ? 64'($urandom) : {$urandom, $urandom},
				($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0, 1'b1);
		end
		plen = pick_plen();
		put_varint(plen, ($urandom_range(0, 4) == 0) ? 1 : 0, 1'b1);
		if (plen <= 64'(cur_max)) begin
			repeat (plen) tok.push_back(8'($urandom));
		end
	endtask

	task automatic emit_frame(input int adj, input logic [7:0] last);
		int flen;
		flen = tok.size() + adj;
		if (flen < 0) flen = 0;
		stream.push_back(cur_magic[15:8]);
		stream.push_back(cur_magic[7:0]);
		put_varint(64'(flen), ($urandom_range(0, 4) == 0) ? 1 : 0, 1'b0);
		foreach (tok[i]) stream.push_back(tok[i]);
		tok.delete();
		stream.push_back(last);
	endtask

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.in_byte <= b;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_stream();
		while (stream.size() > 0) send_byte(stream.pop_front());
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		do @(negedge clk); while (chk_pending != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] d);
		cfg_ch.valid <= 1'b1;
		cfg_ch.reg_index <= idx;
		cfg_ch.wr_data <= d;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
		if (idx == REG_MAGIC_WORD) cur_magic = d;
		else cur_max = d;
	endtask

	task automatic send_directed();
		logic [7:0] mh;
		logic [7:0] ml;
		mh = MAGIC_RESET[15:8];
		ml = MAGIC_RESET[7:0];
		stream = '{mh, ml ^ 8'h01,
			mh, ml, 8'h00, COMMA_CHAR,
			mh, ml, 8'h06, 8'h00, 8'h00, 8'h7F, 8'h02, 8'h00, 8'hFF, COMMA_CHAR + 8'd1,
			mh, ml, 8'h01, 8'h80, 8'hFF,
			mh, ml, 8'h7F, 8'h00, 8'h80, 8'h80, 8'h04,
			mh, ml};
		repeat (MAX_VARINT_BYTES) stream.push_back(8'hFF);
		send_stream();
	endtask

	task automatic random_frame();
		int kind;
		int adj;
		int where;
		logic [7:0] last;
		logic [15:0] word;
		kind = $urandom_range(0, 99);
		burst = ($urandom_range(0, 9) == 0);
		if (kind < 8) begin
			repeat ($urandom_range(1, 6)) stream.push_back(8'($urandom));
		end else if (kind < 14) begin
			word = 16'($urandom);
			if (word == cur_magic) word[0] = ~word[0];
			stream.push_back(word[15:8]);
			stream.push_back(word[7:0]);
		end else if (kind < 20) begin
			where = $urandom_range(0, 2);
			stream.push_back(cur_magic[15:8]);
			stream.push_back(cur_magic[7:0]);
			if (where > 0) stream.push_back(8'h7F);
			if (where > 1) stream.push_back(8'($urandom_range(0, 127)));
			repeat (MAX_VARINT_BYTES) stream.push_back(8'h80 | 8'($urandom));
		end else begin
			repeat ($urandom_range(0, 4)) add_token();
			adj = 0;
			last = COMMA_CHAR;
			if (kind < 28) adj = -$urandom_range(1, 3);
			else if (kind < 32) adj = $urandom_range(1, 2);
			else if (kind < 38) last = 8'($urandom);
			emit_frame(adj, last);
		end
		sent += stream.size();
		send_stream();
	endtask

	initial begin : result_sink
		int stall;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_off = 1'b0;
			end else begin
				stall = pick_gap();
				if (stall == 0) begin
					out_ch.ready <= 1'b1;
				end else begin
					out_ch.ready <= 1'b0;
					repeat (stall - 1) @(negedge clk);
				end
			end
		end
	end

	initial begin : stimulus
		in_ch.valid = 1'b0;
		in_ch.in_byte = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.reg_index = REG_MAGIC_WORD;
		cfg_ch.wr_data = '0;
		cur_magic = MAGIC_RESET;
		cur_max = MAX_PLEN_RESET;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		send_directed();
		for (int p = 0; p < 6; p++) begin
			wait_drained();
			case (p)
				1: begin
					write_reg(REG_MAGIC_WORD, 16'h0000);
					write_reg(REG_MAX_PAYLOAD_LEN, 16'h0000);
				end
				2: begin
					write_reg(REG_MAGIC_WORD, 16'hFFFF);
					write_reg(REG_MAX_PAYLOAD_LEN, 16'hFFFF);
				end
				3: begin
					write_reg(REG_MAGIC_WORD, 16'($urandom));
					write_reg(REG_MAX_PAYLOAD_LEN, 16'($urandom_range(1, 8)));
				end
				4: begin
					write_reg(REG_MAGIC_WORD, 16'($urandom));
					write_reg(REG_MAX_PAYLOAD_LEN, 16'd40);
				end
				5: begin
					write_reg(REG_MAGIC_WORD, MAGIC_RESET);
					write_reg(REG_MAX_PAYLOAD_LEN, 16'd1);
				end
				default: ;
			endcase
			if (p == 2) begin
				hold_off = 1'b1;
				burst = 1'b1;
				repeat (3) begin
					put_varint(64'($urandom), 0, 1'b1);
					put_varint(64'd4, 0, 1'b1);
					repeat (4) tok.push_back(8'($urandom));
				end
				emit_frame(0, COMMA_CHAR);
				send_stream();
				burst = 1'b0;
			end
			sent = 0;
			while (sent < BYTES_PER_PHASE) random_frame();
		end
		burst = 1'b0;
		wait_drained();
		repeat (8) @(negedge clk);
		if (chk_errors == 0 && chk_pending == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin : run_limit
		#(LIMIT_NS);
		$display("*** FAILED ***");
		$finish;
	end

endmodule
